/* hw/rtl/sst_pkg.sv */
// shared widths, codes and types for the sparse set table
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

  localparam int KEYS     = 1024;
  localparam int SLOT_W   = $clog2(KEYS);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int KIND_W   = 3;
  localparam int KEY_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_RANGE    = 2'd2,
    ST_POSITION = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_entry_t;

endpackage
`default_nettype wire

/* hw/rtl/sst_if.sv */
// request and response channel interfaces of the sparse set table
`timescale 1ns / 1ps
`default_nettype none
interface sst_req_if import sst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, kind, key, value, position, input ready);
  modport sink (input valid, kind, key, value, position, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [KEY_W-1:0]    key_out;
  logic [CNT_W-1:0]    count;

  modport source (output valid, status, value_out, key_out, count, input ready);
  modport sink (input valid, status, value_out, key_out, count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sparse_set_table_top.sv */
// sparse set table: key to value map over a packed dense slot array
//
// req carries one item: kind (set, remove, lookup, read at position, clear),
// key, value and position. rsp returns exactly one item per request with
// status, value_out, key_out and the entry count after the item.
// cfg_wr_en / cfg_wr_data write key_limit; write it only while idle.
// The key map is read as the request is accepted, then the slot memory in
// FETCH, and the result is registered at write-back in EXEC; this dependent
// read chain means a new item is not taken until the last reaches write-back.
// The next request is taken in the same cycle as the write-back, with
// write-first bypass on both memories.
// A stalled rsp holds its item; one further request is taken and then
// waits at the write-back step, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the set and sets key_limit to 1024;
// memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sparse_set_table_top import sst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  sst_req_if.sink            req,
  sst_rsp_if.source          rsp
);

  state_t state, state_next;

  logic [LIMIT_W-1:0] key_limit;
  logic [CNT_W-1:0]   occ, occ_next, occ_eff;

  logic [KIND_W-1:0]  item_kind;
  logic [KEY_W-1:0]   item_key;
  logic [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]   item_pos;

  logic [SLOT_W-1:0]  ks_mem [KEYS];
  slot_entry_t        slot_mem [KEYS];

  logic               ks_re, ks_we;
  logic [SLOT_W-1:0]  ks_ra, ks_wa, ks_wd, ks_rd;

  logic               sa_re, sb_re, s_we;
  logic [SLOT_W-1:0]  sa_ra, sb_ra, s_wa;
  slot_entry_t        sa_rd, sb_rd, s_wd;

  logic               accept, fire, present, in_range;
  logic [SLOT_W-1:0]  last;
  status_t            status_next;
  logic [VALUE_W-1:0] vout;
  logic [KEY_W-1:0]   kout;

  always_comb begin
    fire      = (state == S_EXEC) && (!rsp.valid || rsp.ready);
    req.ready = (state == S_IDLE) || fire;
    accept    = req.valid && req.ready;

    present  = ({1'b0, ks_rd} < occ) && (sa_rd.key == item_key);
    in_range = ({1'b0, item_key} < key_limit) && ({1'b0, item_key} < CNT_W'(KEYS));
    last     = occ[SLOT_W-1:0] - SLOT_W'(1);

    occ_next    = occ;
    status_next = ST_OK;
    vout        = '0;
    kout        = '0;
    ks_we       = 1'b0;
    ks_wa       = item_key[SLOT_W-1:0];
    ks_wd       = occ[SLOT_W-1:0];
    s_we        = 1'b0;
    s_wa        = ks_rd;
    s_wd        = '{key: item_key, value: item_value};

    if (fire) begin
      case (item_kind)
        KIND_SET: begin
          if (!in_range) begin
            status_next = ST_RANGE;
          end else if (present) begin
            s_we = 1'b1;
          end else if (occ < CNT_W'(KEYS)) begin
            s_we     = 1'b1;
            s_wa     = occ[SLOT_W-1:0];
            ks_we    = 1'b1;
            occ_next = occ + CNT_W'(1);
          end else begin
            status_next = ST_RANGE;
          end
        end
        KIND_REMOVE: begin
          if (!in_range) begin
            status_next = ST_RANGE;
          end else if (present) begin
            if (ks_rd != last) begin
              s_we  = 1'b1;
              s_wd  = sb_rd;
              ks_we = 1'b1;
              ks_wa = sb_rd.key[SLOT_W-1:0];
              ks_wd = ks_rd;
            end
            occ_next = occ - CNT_W'(1);
          end else begin
            status_next = ST_ABSENT;
          end
        end
        KIND_LOOKUP: begin
          if (!in_range) begin
            status_next = ST_RANGE;
          end else if (present) begin
            vout = sa_rd.value;
          end else begin
            status_next = ST_ABSENT;
          end
        end
        KIND_READ: begin
          if ({1'b0, item_pos} < occ) begin
            vout = sb_rd.value;
            kout = sb_rd.key;
          end else begin
            status_next = ST_POSITION;
          end
        end
        KIND_CLEAR: begin
          occ_next = '0;
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end

    occ_eff = fire ? occ_next : occ;
    ks_re   = accept;
    ks_ra   = req.key[SLOT_W-1:0];
    sb_re   = accept;
    sb_ra   = (req.kind == KIND_READ) ? req.position[SLOT_W-1:0]
                                      : occ_eff[SLOT_W-1:0] - SLOT_W'(1);
    sa_re   = (state == S_FETCH);
    sa_ra   = ks_rd;

    case (state)
      S_IDLE:  state_next = accept ? S_FETCH : S_IDLE;
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_next = accept ? S_FETCH : S_IDLE;
        end else begin
          state_next = S_EXEC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit <= LIMIT_RESET;
      occ       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_limit <= cfg_wr_data;
      end
      if (fire) begin
        occ       <= occ_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= req.kind;
      item_key   <= req.key;
      item_value <= req.value;
      item_pos   <= req.position;
    end
    if (fire) begin
      rsp.status    <= status_next;
      rsp.value_out <= vout;
      rsp.key_out   <= kout;
      rsp.count     <= occ_next;
    end
  end

  // key map, write-first
  always_ff @(posedge clk) begin
    if (ks_we) begin
      ks_mem[ks_wa] <= ks_wd;
    end
    if (ks_re) begin
      ks_rd <= (ks_we && (ks_wa == ks_ra)) ? ks_wd : ks_mem[ks_ra];
    end
  end

  // slot memory: back-reference and value, two read ports, write-first
  always_ff @(posedge clk) begin
    if (s_we) begin
      slot_mem[s_wa] <= s_wd;
    end
    if (sa_re) begin
      sa_rd <= (s_we && (s_wa == sa_ra)) ? s_wd : slot_mem[sa_ra];
    end
    if (sb_re) begin
      sb_rd <= (s_we && (s_wa == sb_ra)) ? s_wd : slot_mem[sb_ra];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sst_checker.sv */
// port-level checks for the sparse set table and their binding
`timescale 1ns / 1ps
`default_nettype none
module sst_checker import sst_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [VALUE_W-1:0]  rsp_value_out,
  input logic [KEY_W-1:0]    rsp_key_out,
  input logic [CNT_W-1:0]    rsp_count
);

  // each item passes through FETCH before the next one can be accepted
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !(req_valid && req_ready))
    else $error("item accepted in consecutive cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_count <= CNT_W'(KEYS)))
    else $error("count beyond table size");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_value_out == '0 && rsp_key_out == '0))
    else $error("failed item carries data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_value_out)
       && $stable(rsp_key_out) && $stable(rsp_count)))
    else $error("stalled result item changed");

endmodule

bind sparse_set_table_top sst_checker u_sst_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_value_out (rsp.value_out),
  .rsp_key_out   (rsp.key_out),
  .rsp_count     (rsp.count)
);
`default_nettype wire
